@@ rtl/ptbl_pkg.sv @@
// ----------------------------------------------------------------------------
// ptbl_pkg: shared types and constants of the paper tape binary loader
// request codes, result codes, address width and helpers for address fields
// ----------------------------------------------------------------------------
package ptbl_pkg;

  // width of the load address counter
  localparam int AddrBits = 12;

  // fixed field widths
  localparam int ReqBits   = 2;
  localparam int ByteBits  = 8;
  localparam int WordBits  = 12;
  localparam int CountBits = 16;

  typedef logic [AddrBits-1:0]  addr_t;
  typedef logic [WordBits-1:0]  word_t;
  typedef logic [CountBits-1:0] count_t;

  // request codes
  localparam logic [ReqBits-1:0] ReqByte    = 2'd0;
  localparam logic [ReqBits-1:0] ReqEof     = 2'd1;
  localparam logic [ReqBits-1:0] ReqRestart = 2'd2;

  // result codes
  localparam logic KindWrite  = 1'b0;
  localparam logic KindFinish = 1'b1;

  // leader byte that ends the load
  localparam logic [ByteBits-1:0] EndOfTape = 8'hFF;

  typedef struct packed {
    logic [ReqBits-1:0]  req_type;
    logic [ByteBits-1:0] tape_byte;
  } request_t;

  typedef struct packed {
    logic   result_kind;
    word_t  write_address;
    word_t  write_data;
    count_t words_loaded;
    word_t  highest_address;
  } result_t;

  // address counter to 12-bit output field
  function automatic word_t addr_to_field(addr_t a);
    logic [31:0] ext;
    ext = 32'(a);
    return ext[WordBits-1:0];
  endfunction

  // 12-bit origin word to address counter
  function automatic addr_t field_to_addr(word_t w);
    logic [31:0] ext;
    ext = 32'(w);
    return ext[AddrBits-1:0];
  endfunction

endpackage

@@ rtl/ptbl_in_reg.sv @@
// ----------------------------------------------------------------------------
// ptbl_in_reg: input register
// holds one accepted request until the decode stage takes it
// ----------------------------------------------------------------------------
module ptbl_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ptbl_pkg::request_t req_i,
  input  logic              take_i,
  output logic              valid_o,
  output ptbl_pkg::request_t req_o
);

  logic               valid_q, valid_d;
  ptbl_pkg::request_t req_q, req_d;
  logic               load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    req_d   = req_q;
    if (load) begin
      valid_d = 1'b1;
      req_d   = req_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

@@ rtl/ptbl_core.sv @@
// ----------------------------------------------------------------------------
// ptbl_core: loader state and per-request decode
// updates phase, frame byte, address, count and maximum; builds the result
// ----------------------------------------------------------------------------
module ptbl_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  ptbl_pkg::request_t req_i,
  output logic               res_valid_o,
  output ptbl_pkg::result_t  res_o
);

  typedef enum logic [1:0] {
    PH_LEADER,
    PH_FIRST,
    PH_SECOND,
    PH_DONE
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [6:0]       high_part_q, high_part_d;
  ptbl_pkg::addr_t  load_address_q, load_address_d;
  ptbl_pkg::count_t word_count_q, word_count_d;
  ptbl_pkg::addr_t  max_address_q, max_address_d;

  logic [12:0]      frame;
  logic [7:0]       b;

  assign b     = req_i.tape_byte;
  assign frame = {high_part_q, b[5:0]};

  always_comb begin
    phase_d        = phase_q;
    high_part_d    = high_part_q;
    load_address_d = load_address_q;
    word_count_d   = word_count_q;
    max_address_d  = max_address_q;
    res_valid_o    = 1'b0;
    res_o          = '0;
    if (fire_i) begin
      priority if (req_i.req_type == ptbl_pkg::ReqRestart) begin
        phase_d        = PH_LEADER;
        high_part_d    = '0;
        load_address_d = '0;
        word_count_d   = '0;
        max_address_d  = '0;
      end else if ((req_i.req_type != ptbl_pkg::ReqByte &&
                    req_i.req_type != ptbl_pkg::ReqEof) || phase_q == PH_DONE) begin
        // unused code or load already over
      end else if (req_i.req_type == ptbl_pkg::ReqEof ||
                   (phase_q == PH_LEADER && b == ptbl_pkg::EndOfTape) ||
                   (phase_q != PH_LEADER && b[7])) begin
        phase_d               = PH_DONE;
        res_valid_o           = 1'b1;
        res_o.result_kind     = ptbl_pkg::KindFinish;
        res_o.words_loaded    = word_count_q;
        res_o.highest_address = ptbl_pkg::addr_to_field(max_address_q);
      end else begin
        unique case (phase_q)
          PH_LEADER, PH_FIRST: begin
            // leader bytes with the top bit set are skipped
            if (!b[7]) begin
              high_part_d = b[6:0];
              phase_d     = PH_SECOND;
            end
          end
          PH_SECOND: begin
            phase_d = PH_FIRST;
            if (frame[12]) begin
              load_address_d = ptbl_pkg::field_to_addr(frame[11:0]);
            end else begin
              res_valid_o         = 1'b1;
              res_o.result_kind   = ptbl_pkg::KindWrite;
              res_o.write_address = ptbl_pkg::addr_to_field(load_address_q);
              res_o.write_data    = frame[11:0];
              word_count_d        = ptbl_pkg::CountBits'(word_count_q + 1'b1);
              if (load_address_q > max_address_q) begin
                max_address_d = load_address_q;
              end
              load_address_d = ptbl_pkg::AddrBits'(load_address_q + 1'b1);
            end
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_LEADER;
      high_part_q    <= '0;
      load_address_q <= '0;
      word_count_q   <= '0;
      max_address_q  <= '0;
    end else begin
      phase_q        <= phase_d;
      high_part_q    <= high_part_d;
      load_address_q <= load_address_d;
      word_count_q   <= word_count_d;
      max_address_q  <= max_address_d;
    end
  end

`ifndef ASSERT_OFF
  a_res_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> fire_i)
    else $error("result without a request");

  a_finish_ends_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.result_kind == ptbl_pkg::KindFinish) |=> phase_q == PH_DONE)
    else $error("finish result did not end the load");

  a_write_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.result_kind == ptbl_pkg::KindWrite) |=>
      word_count_q == ptbl_pkg::CountBits'($past(word_count_q) + 1'b1))
    else $error("write result not counted");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE && req_i.req_type != ptbl_pkg::ReqRestart) |-> !res_valid_o)
    else $error("result after the load finished");
`endif

endmodule

@@ rtl/ptbl_out_fifo.sv @@
// ----------------------------------------------------------------------------
// ptbl_out_fifo: two-entry result buffer
// decouples result production from a stalling receiver
// ----------------------------------------------------------------------------
module ptbl_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  ptbl_pkg::result_t wr_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ptbl_pkg::result_t out_data_o
);

  ptbl_pkg::result_t mem_q [2];
  logic              wptr_q, wptr_d;
  logic              rptr_q, rptr_d;
  logic [1:0]        count_q, count_d;
  logic              rd_en;

  assign out_valid_o = count_q != 2'd0;
  assign full_o      = count_q == 2'd2;
  assign rd_en       = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (wr_en_i) begin
      wptr_d = !wptr_q;
    end
    if (rd_en) begin
      rptr_d = !rptr_q;
    end
    unique case ({wr_en_i, rd_en})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en_i && full_o))
    else $error("write into full result buffer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count out of range");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && !rd_en) |=> count_q == $past(count_q) + 2'd1)
    else $error("result buffer lost a write");
`endif

endmodule

@@ rtl/paper_tape_binary_loader.sv @@
// ----------------------------------------------------------------------------
// paper_tape_binary_loader: binary paper tape loader
// turns a stream of tape bytes into memory writes and final load statistics
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o): one request per handshake, either
//   a tape byte, end of file or a restart for a new tape
//   output channel (out_valid_o / out_ready_i): zero or one result per
//   request, a memory write or the finish record with word count and
//   highest address written
//   path: a request is held in the input register, then decoded into the
//   result buffer, from which its result is offered to the receiver
//   throughput: one request per cycle, set by the state update in the decode
//   stage; requests keep flowing while the receiver is ready
//   stall: the two-entry result buffer absorbs results while the receiver
//   holds out_ready_i low; once full, the decode stage holds its request and
//   in_ready_o drops until a slot frees
//   reset: asynchronous, active low; the loader returns to leader skipping
//   with address, count and maximum cleared, and both buffers are emptied
// ----------------------------------------------------------------------------
module paper_tape_binary_loader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  tape_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [11:0] write_address_o,
  output logic [11:0] write_data_o,
  output logic [15:0] words_loaded_o,
  output logic [11:0] highest_address_o
);

  ptbl_pkg::request_t req_in;
  ptbl_pkg::request_t req_held;
  logic               held_valid;
  logic               fire;
  logic               fifo_full;
  logic               res_valid;
  ptbl_pkg::result_t  res;
  ptbl_pkg::result_t  res_out;

  assign req_in.req_type  = req_type_i;
  assign req_in.tape_byte = tape_byte_i;

  // the decode stage runs whenever it holds a request and a buffer slot is free
  assign fire = held_valid && !fifo_full;

  // input register
  ptbl_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_i      (req_in),
    .take_i     (fire),
    .valid_o    (held_valid),
    .req_o      (req_held)
  );

  // loader state and decode
  ptbl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .req_i       (req_held),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result buffer toward the receiver
  ptbl_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (res_valid),
    .wr_data_i   (res),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (res_out)
  );

  // result fields
  assign result_kind_o     = res_out.result_kind;
  assign write_address_o   = res_out.write_address;
  assign write_data_o      = res_out.write_data;
  assign words_loaded_o    = res_out.words_loaded;
  assign highest_address_o = res_out.highest_address;

endmodule

@@ bench/tb_paper_tape_binary_loader.sv @@
// ----------------------------------------------------------------------------
// tb_paper_tape_binary_loader: self-checking bench for the paper tape loader
// drives tape requests through the valid/ready input channel, predicts each
// memory write and finish record in a bench-side copy of the loader, and
// compares every result field by field under varied idle and stall patterns
// ----------------------------------------------------------------------------
module tb_paper_tape_binary_loader;

  // request code the block must ignore, not named in the package
  localparam logic [ptbl_pkg::ReqBits-1:0] ReqUnused = 2'd3;

  // cycles without any handshake before the run is declared hung
  localparam int StallLimit = 1000;
  // length of the long receiver hold-off
  localparam int HoldCycles = 80;
  // random requests per idle phase, ignored ones not counted
  localparam int PhaseItems = 80;

  // bench-side loader phase
  typedef enum logic [1:0] {PhLeader, PhFirst, PhSecond, PhDone} load_phase_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  req_type_i;
  logic [7:0]  tape_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        result_kind_o;
  logic [11:0] write_address_o;
  logic [11:0] write_data_o;
  logic [15:0] words_loaded_o;
  logic [11:0] highest_address_o;

  // predicted loader state
  load_phase_e      ld_phase;
  logic [6:0]       frame_high;
  ptbl_pkg::addr_t  cur_addr;
  ptbl_pkg::count_t words_written;
  ptbl_pkg::addr_t  top_addr;

  // results the loader still owes, oldest first
  ptbl_pkg::result_t due_results[$];

  // idle and stall shaping, percent of cycles
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;

  int mismatches;
  int requests_sent;
  int phase_requests;
  int writes_seen;
  int finishes_seen;
  int stall_cycles;

  paper_tape_binary_loader u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .tape_byte_i      (tape_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .write_address_o  (write_address_o),
    .write_data_o     (write_data_o),
    .words_loaded_o   (words_loaded_o),
    .highest_address_o(highest_address_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // back to leader skipping with everything cleared
  function automatic void clear_loader();
    ld_phase      = PhLeader;
    frame_high    = '0;
    cur_addr      = '0;
    words_written = '0;
    top_addr      = '0;
  endfunction

  // load is over, owe the statistics record
  function automatic void close_load();
    ptbl_pkg::result_t fin;
    fin = '0;
    fin.result_kind     = ptbl_pkg::KindFinish;
    fin.words_loaded    = words_written;
    fin.highest_address = ptbl_pkg::word_t'(top_addr);
    due_results.push_back(fin);
    ld_phase = PhDone;
  endfunction

  // applies one request to the predicted loader; returns 0 when it is ignored
  function automatic bit decode_tape_request(logic [1:0] req, logic [7:0] tbyte);
    logic [12:0]       frame;
    ptbl_pkg::result_t wr;
    if (req == ptbl_pkg::ReqRestart) begin
      clear_loader();
      return 1'b1;
    end
    if (req == ReqUnused || ld_phase == PhDone) return 1'b0;
    if (req == ptbl_pkg::ReqEof) begin
      // a half-built frame is simply dropped
      close_load();
      return 1'b1;
    end
    if (ld_phase == PhLeader) begin
      if (tbyte == ptbl_pkg::EndOfTape) begin
        close_load();
      end else if (!tbyte[7]) begin
        // first data byte doubles as the first half of a frame
        frame_high = tbyte[6:0];
        ld_phase   = PhSecond;
      end
      return 1'b1;
    end
    if (tbyte[7]) begin
      // any byte with the top bit set inside the data ends the load
      close_load();
      return 1'b1;
    end
    if (ld_phase == PhFirst) begin
      frame_high = tbyte[6:0];
      ld_phase   = PhSecond;
      return 1'b1;
    end
    ld_phase = PhFirst;
    frame    = {frame_high, tbyte[5:0]};
    if (frame[12]) begin
      // origin frame
      cur_addr = ptbl_pkg::addr_t'(frame[11:0]);
      return 1'b1;
    end
    wr = '0;
    wr.result_kind   = ptbl_pkg::KindWrite;
    wr.write_address = ptbl_pkg::word_t'(cur_addr);
    wr.write_data    = frame[11:0];
    due_results.push_back(wr);
    words_written = words_written + 1'b1;
    if (cur_addr > top_addr) top_addr = cur_addr;
    cur_addr = cur_addr + 1'b1;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // offers one request, entered and left at a falling edge
  task automatic send_request(input logic [1:0] req, input logic [7:0] tbyte);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    // payload is fixed from here on, so the order of requests is already known
    if (decode_tape_request(req, tbyte)) phase_requests++;
    requests_sent++;
    in_valid_i  = 1'b1;
    req_type_i  = req;
    tape_byte_i = tbyte;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // one 13-bit frame as two tape bytes; bit 6 of the second byte is junk
  task automatic send_frame(input bit origin, input logic [11:0] val);
    send_request(ptbl_pkg::ReqByte, {1'b0, origin, val[11:6]});
    send_request(ptbl_pkg::ReqByte, {1'b0, 1'($urandom_range(1, 0)), val[5:0]});
  endtask

  // pause the sender until the loader owes nothing
  task automatic wait_drain();
    while (due_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver: random stalls, or a solid hold-off while hold_off is set
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) begin
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    ptbl_pkg::result_t got;
    ptbl_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.result_kind     = result_kind_o;
      got.write_address   = write_address_o;
      got.write_data      = write_data_o;
      got.words_loaded    = words_loaded_o;
      got.highest_address = highest_address_o;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: kind %0d addr %03h data %03h words %0d high %03h",
                   got.result_kind, got.write_address, got.write_data,
                   got.words_loaded, got.highest_address);
        end
      end else begin
        want = due_results.pop_front();
        if (want.result_kind == ptbl_pkg::KindWrite) writes_seen++;
        else finishes_seen++;
        if (got.result_kind !== want.result_kind ||
            got.write_address !== want.write_address ||
            got.write_data !== want.write_data ||
            got.words_loaded !== want.words_loaded ||
            got.highest_address !== want.highest_address) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected kind %0d addr %03h data %03h words %0d high %03h",
                     want.result_kind, want.write_address, want.write_data,
                     want.words_loaded, want.highest_address);
            $display("          actual   kind %0d addr %03h data %03h words %0d high %03h",
                     got.result_kind, got.write_address, got.write_data,
                     got.words_loaded, got.highest_address);
          end
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d results owed",
                 stall_cycles, due_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // leader skipping at both ends of its range, end-of-tape byte, then ignored requests
  task automatic test_leader_skip();
    send_request(ptbl_pkg::ReqRestart, 8'h00);
    send_request(ptbl_pkg::ReqByte, 8'h80);
    send_request(ptbl_pkg::ReqByte, 8'hFE);
    send_request(ptbl_pkg::ReqByte, ptbl_pkg::EndOfTape);  // nothing written
    send_request(ptbl_pkg::ReqByte, 8'h12);       // finished, ignored
    send_request(ptbl_pkg::ReqEof, 8'h00);        // end of file when finished, ignored
    send_request(ReqUnused, 8'hFF);               // unused request type, ignored
    wait_drain();
  endtask

  // origin at the top of memory, address wrap, masked second byte, high byte mid-data
  task automatic test_origin_and_wrap();
    send_request(ptbl_pkg::ReqRestart, 8'hFF);
    send_request(ptbl_pkg::ReqByte, 8'h80);
    send_request(ptbl_pkg::ReqByte, 8'h7F);       // origin frame 07777
    send_request(ptbl_pkg::ReqByte, 8'h3F);
    send_request(ptbl_pkg::ReqByte, 8'h3F);       // word 07777 at 07777
    send_request(ptbl_pkg::ReqByte, 8'h3F);
    send_request(ptbl_pkg::ReqByte, 8'h00);       // word 0 at address 0 after wrap
    send_request(ptbl_pkg::ReqByte, 8'h40);       // bit 6 of the second byte dropped
    send_request(ptbl_pkg::ReqByte, 8'hFF);       // top bit set between frames ends the load
    wait_drain();
  endtask

  // end of file with half a frame, and an unused request inside the data
  task automatic test_half_frame_and_noise();
    send_request(ptbl_pkg::ReqRestart, 8'h00);
    send_request(ptbl_pkg::ReqByte, 8'h01);
    send_request(ReqUnused, 8'h00);
    send_request(ptbl_pkg::ReqByte, 8'h02);       // word 0102 at 0
    send_request(ptbl_pkg::ReqByte, 8'h03);
    send_request(ptbl_pkg::ReqEof, 8'hAA);        // half frame lost
    send_request(ptbl_pkg::ReqRestart, 8'h00);
    send_request(ptbl_pkg::ReqEof, 8'h00);        // end of file straight in the leader
    wait_drain();
  endtask

  // restart in the middle of a load clears the count and the maximum
  task automatic test_restart_mid_load();
    send_request(ptbl_pkg::ReqRestart, 8'h00);
    send_frame(1'b1, 12'h123);
    send_frame(1'b0, 12'hABC);
    send_request(ptbl_pkg::ReqRestart, 8'h55);
    send_frame(1'b0, 12'h001);
    send_request(ptbl_pkg::ReqByte, 8'h80);       // high byte in the first half of a frame
    wait_drain();
  endtask

  // long receiver hold-off while the sender keeps offering data frames
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(ptbl_pkg::ReqRestart, 8'h00);
    fork
      begin
        @(posedge clk_i);
        hold_off = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        repeat (20) send_frame(1'b0, 12'($urandom_range(4095, 0)));
        send_request(ptbl_pkg::ReqEof, 8'h00);
      end
    join
    wait_drain();
  endtask

  // one random tape, mostly well formed, with various ways to end it
  task automatic send_random_tape();
    int n_words;
    send_request(ptbl_pkg::ReqRestart, 8'($urandom_range(255, 0)));
    repeat ($urandom_range(3, 0)) begin
      send_request(ptbl_pkg::ReqByte, 8'($urandom_range(254, 128)));
    end
    if ($urandom_range(3, 0) != 0) send_frame(1'b1, 12'($urandom_range(4095, 0)));
    n_words = $urandom_range(12, 1);
    repeat (n_words) begin
      if ($urandom_range(9, 0) == 0) send_frame(1'b1, 12'($urandom_range(4095, 0)));
      else send_frame(1'b0, 12'($urandom_range(4095, 0)));
    end
    case ($urandom_range(4, 0))
      0: send_request(ptbl_pkg::ReqEof, 8'($urandom_range(255, 0)));
      1: send_request(ptbl_pkg::ReqByte, 8'($urandom_range(255, 128)));
      2: begin
        // broken frame
        send_request(ptbl_pkg::ReqByte, 8'($urandom_range(127, 0)));
        if ($urandom_range(1, 0) != 0) send_request(ptbl_pkg::ReqEof, 8'h00);
        else send_request(ptbl_pkg::ReqByte, 8'($urandom_range(255, 128)));
      end
      3: begin
        // trailer with junk after the end
        send_request(ptbl_pkg::ReqByte, 8'($urandom_range(255, 128)));
        repeat ($urandom_range(3, 1)) begin
          send_request(ptbl_pkg::ReqByte, 8'($urandom_range(255, 0)));
        end
      end
      default: ;  // left open, the next restart abandons it
    endcase
  endtask

  // random tapes and loose noise under one idle and stall setting
  task automatic test_random_tapes(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    phase_requests = 0;
    while (phase_requests < PhaseItems) begin
      if ($urandom_range(9, 0) == 0) begin
        send_request(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
      end else begin
        send_random_tape();
      end
    end
    wait_drain();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = ptbl_pkg::ReqByte;
    tape_byte_i    = '0;
    out_ready_i    = 1'b0;
    hold_off       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    requests_sent  = 0;
    phase_requests = 0;
    writes_seen    = 0;
    finishes_seen  = 0;
    stall_cycles   = 0;
    clear_loader();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_leader_skip();
    test_origin_and_wrap();
    test_half_frame_and_noise();
    test_restart_mid_load();
    test_backpressure();
    test_random_tapes(0, 0);
    test_random_tapes(68, 0);
    test_random_tapes(0, 68);
    test_random_tapes(26, 26);

    // let anything stray come out of the two-stage pipeline
    wait_drain();
    repeat (8) @(posedge clk_i);

    $display("covered %0d requests: %0d memory writes and %0d load finishes checked",
             requests_sent, writes_seen, finishes_seen);
    $display("idle phases, a long receiver hold-off and an address wrap, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
